// ----- sv/cqo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collapsing queue package
// Shared constants, result codes and the per-cell control word used by the
// main queue and overflow chains.
// ----------------------------------------------------------------------------
package cqo_pkg;

  // Default sizes of the two stores and of the ID key.
  localparam int MAIN_DEPTH_DEF = 12;
  localparam int WAIT_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF    = 16;

  // Result codes reported with every word.
  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_WAITING   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_WAIT_FULL = 3'd5
  } status_t;

  // Control word for one storage cell.
  typedef struct packed {
    logic load;   // take the load data
    logic shift;  // take the neighbor's data when at or past the hit
  } cell_ctl_t;

endpackage

// ----- sv/cqo_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collapsing queue storage cell
// Holds one ID, compares it against the captured key, passes a running
// "at or past the hit" flag down the chain and takes its right neighbor's ID
// when the chain collapses.
// ----------------------------------------------------------------------------
module cqo_cell #(
  parameter int ID_BITS = cqo_pkg::ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  capture,
  input  logic                  occ,
  input  logic [ID_BITS-1:0]    key,
  input  cqo_pkg::cell_ctl_t    ctl,
  input  logic [ID_BITS-1:0]    load_id,
  input  logic [ID_BITS-1:0]    next_id,
  input  logic                  past_in,
  output logic                  past_out,
  output logic [ID_BITS-1:0]    id,
  output logic                  hit
);
  import cqo_pkg::*;

  // The flag is set in this cell and every cell after the matching one.
  assign past_out = past_in || hit;

  // Match capture on accept, then load or collapse on the update cycle.
  always_ff @(posedge clk) begin
    if (capture) begin
      hit <= occ && (id == key);
    end
    if (ctl.load) begin
      id <= load_id;
    end else if (ctl.shift && past_out) begin
      id <= next_id;
    end
  end

endmodule

// ----- sv/collapsing_queue_with_overflow_top.sv -----
`timescale 1ns / 1ps
// A result word is registered by the update step that follows acceptance of
// its request word; the update waits while the result side stalls.
// No new request is taken until the update of the last one is done; the
// accepting edge captures the key match in every cell, and the update then
// changes the cell chains and the fill counters.
// Reset clears the fill counters, the sequencer and the result valid; slot
// contents are not cleared.
// ----------------------------------------------------------------------------
// Collapsing queue with overflow FIFO
// Ordered main queue of IDs built from a row of cells that collapses on
// removal, backed by a shifting overflow chain that refills the main queue.
// ----------------------------------------------------------------------------
module collapsing_queue_with_overflow_top #(
  parameter int MAIN_DEPTH = cqo_pkg::MAIN_DEPTH_DEF,
  parameter int WAIT_DEPTH = cqo_pkg::WAIT_DEPTH_DEF,
  parameter int ID_BITS    = cqo_pkg::ID_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic [ID_BITS-1:0]                plane_id,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        status,
  output logic                              promoted_valid,
  output logic [ID_BITS-1:0]                promoted_id,
  output logic [$clog2(MAIN_DEPTH+1)-1:0]   main_count,
  output logic [$clog2(WAIT_DEPTH+1)-1:0]   wait_count
);
  import cqo_pkg::*;

  localparam int MFW = $clog2(MAIN_DEPTH + 1);
  localparam int WFW = $clog2(WAIT_DEPTH + 1);
  localparam logic [MFW-1:0] MAIN_CAP = MFW'(MAIN_DEPTH);
  localparam logic [WFW-1:0] WAIT_CAP = WFW'(WAIT_DEPTH);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t               state;
  logic                 mode_q;
  logic [ID_BITS-1:0]   key_q;
  logic [MFW-1:0]       main_fill;
  logic [WFW-1:0]       wait_fill;

  logic                 in_take;
  logic                 out_free;
  logic                 exec_go;

  // Cell chain signals.
  logic [ID_BITS-1:0]   main_id   [MAIN_DEPTH];
  logic [MAIN_DEPTH-1:0] main_hit;
  logic [MAIN_DEPTH-1:0] main_occ;
  logic [MAIN_DEPTH-1:0] main_past;
  cell_ctl_t            main_ctl  [MAIN_DEPTH];
  logic [ID_BITS-1:0]   wait_id   [WAIT_DEPTH];
  logic [WAIT_DEPTH-1:0] wait_hit;
  logic [WAIT_DEPTH-1:0] wait_occ;
  logic [WAIT_DEPTH-1:0] wait_past;
  cell_ctl_t            wait_ctl  [WAIT_DEPTH];

  // Update decisions.
  logic                 main_load;
  logic [MFW-1:0]       main_pos;
  logic [ID_BITS-1:0]   main_load_id;
  logic                 main_shift;
  logic                 wait_load;
  logic                 wait_pop;
  logic                 removed;
  logic                 promote;
  logic [MFW-1:0]       fill_after;
  logic [MFW-1:0]       main_fill_next;
  logic [WFW-1:0]       wait_fill_next;
  status_t              st_next;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign exec_go  = (state == S_EXEC) && out_free;

  // Main queue cells: cell 0 is the oldest entry.
  assign main_past[0] = 1'b0;
  for (genvar i = 0; i < MAIN_DEPTH; i++) begin : g_main
    logic [ID_BITS-1:0] nbr;
    logic               po;

    assign main_occ[i]       = (main_fill > MFW'(i));
    assign main_ctl[i].load  = main_load && (main_pos == MFW'(i));
    assign main_ctl[i].shift = main_shift;

    if (i + 1 < MAIN_DEPTH) begin : g_mid
      assign nbr            = main_id[i+1];
      assign main_past[i+1] = po;
    end else begin : g_end
      assign nbr = '0;
    end

    cqo_cell #(.ID_BITS(ID_BITS)) u_cell (
      .clk      (clk),
      .capture  (in_take),
      .occ      (main_occ[i]),
      .key      (plane_id),
      .ctl      (main_ctl[i]),
      .load_id  (main_load_id),
      .next_id  (nbr),
      .past_in  (main_past[i]),
      .past_out (po),
      .id       (main_id[i]),
      .hit      (main_hit[i])
    );
  end

  // Overflow cells: cell 0 is the FIFO head; a pop shifts the whole chain.
  assign wait_past[0] = 1'b1;
  for (genvar j = 0; j < WAIT_DEPTH; j++) begin : g_wait
    logic [ID_BITS-1:0] nbr;
    logic               po;

    assign wait_occ[j]       = (wait_fill > WFW'(j));
    assign wait_ctl[j].load  = wait_load && (wait_fill == WFW'(j));
    assign wait_ctl[j].shift = wait_pop;

    if (j + 1 < WAIT_DEPTH) begin : g_mid
      assign nbr            = wait_id[j+1];
      assign wait_past[j+1] = po;
    end else begin : g_end
      assign nbr = '0;
    end

    cqo_cell #(.ID_BITS(ID_BITS)) u_cell (
      .clk      (clk),
      .capture  (in_take),
      .occ      (wait_occ[j]),
      .key      (plane_id),
      .ctl      (wait_ctl[j]),
      .load_id  (key_q),
      .next_id  (nbr),
      .past_in  (wait_past[j]),
      .past_out (po),
      .id       (wait_id[j]),
      .hit      (wait_hit[j])
    );
  end

  // Decide the update from the captured match bits.
  always_comb begin
    main_load      = 1'b0;
    main_pos       = main_fill;
    main_load_id   = key_q;
    main_shift     = 1'b0;
    wait_load      = 1'b0;
    wait_pop       = 1'b0;
    removed        = |main_hit;
    fill_after     = main_fill - MFW'(removed);
    promote        = 1'b0;
    main_fill_next = main_fill;
    wait_fill_next = wait_fill;
    st_next        = ST_DUPLICATE;

    if (!mode_q) begin
      // Enter: reject duplicates, then fill main, then overflow.
      if ((|main_hit) || (|wait_hit)) begin
        st_next = ST_DUPLICATE;
      end else if (main_fill != MAIN_CAP) begin
        main_load      = exec_go;
        main_fill_next = main_fill + MFW'(1);
        st_next        = ST_STORED;
      end else if (wait_fill != WAIT_CAP) begin
        wait_load      = exec_go;
        wait_fill_next = wait_fill + WFW'(1);
        st_next        = ST_WAITING;
      end else begin
        st_next = ST_WAIT_FULL;
      end
    end else begin
      // Exit: collapse over the matching slot, then refill from the FIFO head.
      st_next    = removed ? ST_REMOVED : ST_NOT_FOUND;
      main_shift = exec_go && removed;
      promote    = (wait_fill != '0) && (fill_after != MAIN_CAP);
      main_pos   = fill_after;
      main_load_id = wait_id[0];
      main_load  = exec_go && promote;
      wait_pop   = exec_go && promote;
      main_fill_next = fill_after + MFW'(promote);
      wait_fill_next = wait_fill - WFW'(promote);
    end
  end

  // Sequencer, fill counters and the result word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      main_fill      <= '0;
      wait_fill      <= '0;
      out_valid      <= 1'b0;
      status         <= '0;
      promoted_valid <= 1'b0;
      promoted_id    <= '0;
      main_count     <= '0;
      wait_count     <= '0;
      mode_q         <= 1'b0;
      key_q          <= '0;
    end else begin
      // The result valid is set by an update and cleared once the word is taken.
      if (exec_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            mode_q <= mode;
            key_q  <= plane_id;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            main_fill      <= main_fill_next;
            wait_fill      <= wait_fill_next;
            status         <= st_next;
            promoted_valid <= promote;
            promoted_id    <= promote ? wait_id[0] : '0;
            main_count     <= main_fill_next;
            wait_count     <= wait_fill_next;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The overflow FIFO only holds entries while the main queue is full.
  a_wait_needs_full_main: assert property (@(posedge clk) disable iff (rst)
    (wait_fill != '0) |-> (main_fill == MAIN_CAP))
    else $error("overflow holds entries while the main queue has room");

  // Keys are unique across both stores, so at most one cell can match.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $onehot0({main_hit, wait_hit}))
    else $error("more than one cell matched the key");

  // A promotion only follows a removal from the main queue.
  a_promote_after_remove: assert property (@(posedge clk) disable iff (rst)
    (out_valid && promoted_valid) |-> (status == ST_REMOVED))
    else $error("promotion reported without a removal");

  // Fill counters never pass their capacity.
  a_fill_bounds: assert property (@(posedge clk) disable iff (rst)
    (main_fill <= MAIN_CAP) && (wait_fill <= WAIT_CAP))
    else $error("fill counter past capacity");

endmodule
